>>> hw/rtl/ssp_pkg.sv
`default_nettype none
package ssp_pkg;

  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_ACCEPT = 2'd1;
  localparam logic [1:0] K_ENTRY  = 2'd2;
  localparam logic [1:0] K_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_HEX   = 2'd1;
  localparam logic [1:0] ERR_CKSUM = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] SUM_OK  = 8'hFF;
  localparam logic [3:0] ENTRY_BASE = 4'd11;
  localparam logic [31:0] ADDR_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_CKSUM,
    PH_SKIP
  } ph_t;

  typedef struct packed {
    logic       nl;
    logic       is_s;
    logic       type_ok;
    logic [3:0] digit;
    logic       hex_ok;
    logic [3:0] nib;
  } tok_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssp_front.sv
`default_nettype none
module ssp_front
  import ssp_pkg::*;
(
  input  wire logic [7:0] character,
  output tok_t            tok
);

  always_comb begin
    tok.nl      = (character == CHAR_NL);
    tok.is_s    = (character == CHAR_S);
    tok.digit   = character[3:0];
    tok.type_ok = ((character >= 8'h31) && (character <= 8'h33)) ||
                  ((character >= 8'h37) && (character <= 8'h39));
    tok.hex_ok  = 1'b1;
    tok.nib     = 4'd0;
    if ((character >= 8'h30) && (character <= 8'h39)) begin
      tok.nib = character[3:0];
    end else if ((character >= 8'h41) && (character <= 8'h46)) begin
      tok.nib = 4'(character[3:0] + 4'd9);
    end else if ((character >= 8'h61) && (character <= 8'h66)) begin
      tok.nib = 4'(character[3:0] + 4'd9);
    end else begin
      tok.hex_ok = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssp_fifo.sv
`default_nettype none
module ssp_fifo
  import ssp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  tok_t      wr_data,
  output logic      full,
  input  wire logic rd_en,
  output tok_t      rd_data,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tok_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssp_back.sv
`default_nettype none
module ssp_back
  import ssp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  tok_t      tok,
  input  wire logic tok_valid,
  output logic      tok_pop,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  ph_t         phase_r, phase_nxt;
  logic [3:0]  rtype_r, rtype_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  bleft_r, bleft_nxt;
  logic [2:0]  aleft_r, aleft_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] high_r, high_nxt;
  logic        halt_r, halt_nxt;
  logic        res_valid_r;
  res_t        res_r;

  logic        emit;
  res_t        res_c;
  logic        is_data;
  logic [7:0]  b;
  logic [2:0]  ab;
  logic [2:0]  aleft_dec;
  logic [7:0]  bleft_dec;
  logic [7:0]  sum_add;
  logic [31:0] acc_shift;

  assign tok_pop   = tok_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt  = phase_r;
    rtype_nxt  = rtype_r;
    hi_nib_nxt = hi_nib_r;
    pend_nxt   = pend_r;
    bleft_nxt  = bleft_r;
    aleft_nxt  = aleft_r;
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    halt_nxt   = halt_r;
    emit       = 1'b0;
    res_c      = '0;
    is_data    = (rtype_r <= 4'd3);
    b          = {hi_nib_r, tok.nib};
    ab         = is_data ? 3'(rtype_r + 4'd1) : 3'(ENTRY_BASE - rtype_r);
    aleft_dec  = aleft_r - 3'd1;
    bleft_dec  = bleft_r - 8'd1;
    sum_add    = sum_r + b;
    acc_shift  = {acc_r[23:0], b};

    if (tok_pop && !halt_r) begin
      if (tok.nl) begin
        phase_nxt = PH_LINE_START;
        pend_nxt  = 1'b0;
      end else begin
        unique case (phase_r)
          PH_LINE_START: begin
            phase_nxt = tok.is_s ? PH_TYPE : PH_SKIP;
          end
          PH_TYPE: begin
            if (tok.type_ok) begin
              rtype_nxt = tok.digit;
              phase_nxt = PH_COUNT;
              pend_nxt  = 1'b0;
              sum_nxt   = '0;
              acc_nxt   = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_COUNT, PH_ADDR, PH_DATA, PH_CKSUM: begin
            if (!tok.hex_ok) begin
              halt_nxt         = 1'b1;
              emit             = 1'b1;
              res_c.kind       = K_ERROR;
              res_c.error_code = ERR_HEX;
            end else if (!pend_r) begin
              hi_nib_nxt = tok.nib;
              pend_nxt   = 1'b1;
            end else begin
              pend_nxt = 1'b0;
              unique case (phase_r)
                PH_COUNT: begin
                  sum_nxt = b;
                  if (is_data && (b < (8'(ab) + 8'd1))) begin
                    phase_nxt = PH_SKIP;
                  end else begin
                    bleft_nxt = is_data ? (b - 8'(ab) - 8'd1) : 8'd0;
                    aleft_nxt = ab;
                    phase_nxt = PH_ADDR;
                  end
                end
                PH_ADDR: begin
                  sum_nxt   = sum_add;
                  acc_nxt   = acc_shift;
                  aleft_nxt = aleft_dec;
                  if (aleft_dec == 3'd0) begin
                    if (!is_data) begin
                      phase_nxt     = PH_SKIP;
                      emit          = 1'b1;
                      res_c.kind    = K_ENTRY;
                      res_c.address = acc_shift;
                    end else begin
                      if (acc_shift < low_r) begin
                        low_nxt = acc_shift;
                      end
                      phase_nxt = (bleft_r != 8'd0) ? PH_DATA : PH_CKSUM;
                    end
                  end
                end
                PH_DATA: begin
                  sum_nxt   = sum_add;
                  acc_nxt   = acc_r + 32'd1;
                  bleft_nxt = bleft_dec;
                  if (bleft_dec == 8'd0) begin
                    phase_nxt = PH_CKSUM;
                  end
                  emit            = 1'b1;
                  res_c.kind      = K_DATA;
                  res_c.address   = acc_r;
                  res_c.data_byte = b;
                end
                default: begin
                  sum_nxt = sum_add;
                  emit    = 1'b1;
                  if (sum_add != SUM_OK) begin
                    halt_nxt         = 1'b1;
                    res_c.kind       = K_ERROR;
                    res_c.error_code = ERR_CKSUM;
                  end else begin
                    if (acc_r > high_r) begin
                      high_nxt = acc_r;
                    end
                    phase_nxt        = PH_SKIP;
                    res_c.kind       = K_ACCEPT;
                    res_c.range_low  = low_r;
                    res_c.range_high = (acc_r > high_r) ? acc_r : high_r;
                  end
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      res_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE_START;
      rtype_r     <= '0;
      hi_nib_r    <= '0;
      pend_r      <= 1'b0;
      bleft_r     <= '0;
      aleft_r     <= '0;
      acc_r       <= '0;
      sum_r       <= '0;
      low_r       <= ADDR_ONES;
      high_r      <= '0;
      halt_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rtype_r  <= rtype_nxt;
      hi_nib_r <= hi_nib_nxt;
      pend_r   <= pend_nxt;
      bleft_r  <= bleft_nxt;
      aleft_r  <= aleft_nxt;
      acc_r    <= acc_nxt;
      sum_r    <= sum_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      halt_r   <= halt_nxt;
      if (tok_pop && emit) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/srecord_stream_parser_top.sv
`default_nettype none
// Characters enter the token queue; each result beat is held in the output register.
// Throughput: one character per cycle while the queue is not full; the parser pops
// one queued token per cycle whenever the output register is empty or being drained.
// Classifier and parser are decoupled by a QDEPTH-entry token queue.
// Reset (rst_n low, synchronous) empties the queue and output register and clears
// the address range and halt state; parsing halts after an error until reset.
module srecord_stream_parser_top
  import ssp_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_character,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_address,
  output logic [7:0]       out_data_byte,
  output logic [1:0]       out_error_code,
  output logic [31:0]      out_range_low,
  output logic [31:0]      out_range_high
);

  tok_t tok_in, tok_out;
  logic full, empty, pop;
  res_t res;

  assign in_ready = !full;

  ssp_front u_front (
    .character (in_character),
    .tok       (tok_in)
  );

  ssp_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_valid && !full),
    .wr_data (tok_in),
    .full    (full),
    .rd_en   (pop),
    .rd_data (tok_out),
    .empty   (empty)
  );

  ssp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok_out),
    .tok_valid (!empty),
    .tok_pop   (pop),
    .res_valid (out_valid),
    .res       (res),
    .res_ready (out_ready)
  );

  assign out_kind       = res.kind;
  assign out_address    = res.address;
  assign out_data_byte  = res.data_byte;
  assign out_error_code = res.error_code;
  assign out_range_low  = res.range_low;
  assign out_range_high = res.range_high;

endmodule
`default_nettype wire

>>> hw/rtl/ssp_checker.sv
`default_nettype none
module ssp_checker
  import ssp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_character,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [31:0] out_address,
  input wire logic [7:0]  out_data_byte,
  input wire logic [1:0]  out_error_code,
  input wire logic [31:0] out_range_low,
  input wire logic [31:0] out_range_high
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_character))
    else $error("input beat dropped or changed while stalled");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_address) &&
      $stable(out_data_byte) && $stable(out_error_code) && $stable(out_range_low) &&
      $stable(out_range_high))
    else $error("result beat changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code disagrees with kind");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == K_ERROR) |=> !out_valid)
    else $error("result beat after error");

  a_accept_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_ACCEPT) |->
      (out_address == 32'd0) && (out_data_byte == 8'd0))
    else $error("accept beat carries address or data");

endmodule

bind srecord_stream_parser_top ssp_checker u_ssp_checker (.*);
`default_nettype wire
